@@ src/cdc_pkg.sv @@
package cdc_pkg;

   localparam int YEAR_BITS_DEFAULT = 14;
   localparam int NEW_YEAR_BITS     = 14;
   localparam int MIN_YEAR_BITS     = 14;
   localparam int RESET_YEAR        = 2019;
   localparam logic [MIN_YEAR_BITS-1:0] MIN_YEAR_RESET = 14'd1990;

   // divisibility by 25 through the multiplicative inverse modulo 2^16
   localparam logic [15:0] INV25       = 16'd23593;
   localparam logic [15:0] DIV25_LIMIT = 16'd2621;

   // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT for y below 2^16
   localparam logic [17:0] DIV100_MUL   = 18'd167773;
   localparam int          DIV100_SHIFT = 24;

   localparam int SUM_BITS = 20;

   typedef enum logic {
      OP_ADVANCE = 1'b0,
      OP_SET     = 1'b1
   } op_type;

   function automatic logic is_leap(input logic [15:0] year);
      logic [31:0] prod;
      logic        div25;
      prod  = 32'(year) * 32'(INV25);
      div25 = (prod[15:0] <= DIV25_LIMIT);
      return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         4'd2: begin
            days = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            days = 5'd30;
         end
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
            days = 5'd31;
         end
         default: begin
            days = 5'd0;
         end
      endcase
      return days;
   endfunction

   function automatic logic [2:0] month_offset(input logic [3:0] month);
      logic [2:0] offset;
      case (month)
         4'd1:  offset = 3'd0;
         4'd2:  offset = 3'd3;
         4'd3:  offset = 3'd2;
         4'd4:  offset = 3'd5;
         4'd5:  offset = 3'd0;
         4'd6:  offset = 3'd3;
         4'd7:  offset = 3'd5;
         4'd8:  offset = 3'd1;
         4'd9:  offset = 3'd4;
         4'd10: offset = 3'd6;
         4'd11: offset = 3'd2;
         4'd12: offset = 3'd4;
         default: offset = 3'd0;
      endcase
      return offset;
   endfunction

   // fold octal digits, since 8 is 1 modulo 7
   function automatic logic [2:0] mod7(input logic [SUM_BITS-1:0] value);
      logic [5:0] fold_a;
      logic [3:0] fold_b;
      logic [3:0] fold_c;
      fold_a = 6'(value[2:0]) + 6'(value[5:3]) + 6'(value[8:6]) + 6'(value[11:9])
             + 6'(value[14:12]) + 6'(value[17:15]) + 6'(value[19:18]);
      fold_b = 4'(fold_a[5:3]) + 4'(fold_a[2:0]);
      fold_c = 4'(fold_b[3]) + 4'(fold_b[2:0]);
      return (fold_c == 4'd7) ? 3'd0 : fold_c[2:0];
   endfunction

endpackage

@@ src/cdc_req_if.sv @@
interface cdc_req_if;
   logic                               valid;
   logic                               ready;
   logic                               operation;
   logic [3:0]                         new_month;
   logic [4:0]                         new_day;
   logic [cdc_pkg::NEW_YEAR_BITS-1:0]  new_year;

   modport source (output valid, operation, new_month, new_day, new_year, input ready);
   modport sink   (input valid, operation, new_month, new_day, new_year, output ready);
endinterface

@@ src/cdc_rsp_if.sv @@
interface cdc_rsp_if #(
   parameter int YEAR_BITS = cdc_pkg::YEAR_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [3:0]           cur_month;
   logic [4:0]           cur_day;
   logic [YEAR_BITS-1:0] cur_year;
   logic [2:0]           weekday;
   logic                 accepted;

   modport source (output valid, cur_month, cur_day, cur_year, weekday, accepted, input ready);
   modport sink   (input valid, cur_month, cur_day, cur_year, weekday, accepted, output ready);
endinterface

@@ src/calendar_date_counter_unit.sv @@
// Calendar date counter.
// req_chan carries one item per handshake: operation advance moves the stored
// date on by one day, operation set loads new_month/new_day/new_year when the
// date is valid and new_year is at least the min_year register; otherwise the
// stored date is kept. rsp_chan returns one item per request item with the
// stored date after that item, its weekday (0 Sunday) and the accepted flag.
// csr_write_enable/csr_write_data write min_year; write it only while idle.
// From request handshake to response valid an item passes the input
// register, date update (the only feedback loop, so an item may follow
// every cycle while rsp_chan.ready is high), divide-by-100 multiply, then
// weekday sum into the output register.
// Throughput is one item per cycle while rsp_chan.ready is high.
// When the receiver stalls, the pipeline fills and req_chan.ready drops once
// all four stages hold items; nothing is dropped.
// Reset (synchronous, active high) empties the pipeline, sets the date to
// 1 January 2019 and min_year to 1990.
module calendar_date_counter_unit #(
   parameter int YEAR_BITS = cdc_pkg::YEAR_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   cdc_req_if.sink                            req_chan,
   cdc_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [cdc_pkg::MIN_YEAR_BITS-1:0]  csr_write_data
);

   localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;
   localparam int Q_BITS = YEAR_BITS - 6;
   localparam int PROD_BITS = YEAR_BITS + 18;
   localparam int SUM_BITS = cdc_pkg::SUM_BITS;

   logic [cdc_pkg::MIN_YEAR_BITS-1:0] min_year_ff;

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                 s1_free, s2_free, s3_free, s4_free;

   cdc_pkg::op_type                   s1_op_ff;
   logic [3:0]                        s1_month_ff;
   logic [4:0]                        s1_day_ff;
   logic [cdc_pkg::NEW_YEAR_BITS-1:0] s1_year_ff;

   logic [3:0]           month_ff, month_in;
   logic [4:0]           day_ff, day_in;
   logic [YEAR_BITS-1:0] year_ff, year_in;
   logic                 ok_in;
   logic [15:0]          leap_year;
   logic                 leap;
   logic [4:0]           set_len, cur_len;

   logic [3:0]           s2_month_ff;
   logic [4:0]           s2_day_ff;
   logic [YEAR_BITS-1:0] s2_year_ff;
   logic                 s2_ok_ff;

   logic [YEAR_BITS-1:0] adj_year;
   logic [PROD_BITS-1:0] div_prod;

   logic [3:0]           s3_month_ff;
   logic [4:0]           s3_day_ff;
   logic [YEAR_BITS-1:0] s3_year_ff;
   logic                 s3_ok_ff;
   logic [YEAR_BITS-1:0] s3_adj_ff;
   logic [Q_BITS-1:0]    s3_q100_ff;
   logic [5:0]           s3_od_ff;

   logic [SUM_BITS-1:0]  wd_sum;

   logic [3:0]           s4_month_ff;
   logic [4:0]           s4_day_ff;
   logic [YEAR_BITS-1:0] s4_year_ff;
   logic [2:0]           s4_weekday_ff;
   logic                 s4_ok_ff;

   assign s4_free = !s4_valid_ff || rsp_chan.ready;
   assign s3_free = !s3_valid_ff || s4_free;
   assign s2_free = !s2_valid_ff || s3_free;
   assign s1_free = !s1_valid_ff || s2_free;
   assign req_chan.ready = s1_free && !reset;

   always_comb begin
      leap_year = (s1_op_ff == cdc_pkg::OP_SET) ? 16'(s1_year_ff) : 16'(year_ff);
      leap      = cdc_pkg::is_leap(leap_year);
      set_len   = cdc_pkg::month_days(s1_month_ff, leap);
      cur_len   = cdc_pkg::month_days(month_ff, leap);
      month_in  = month_ff;
      day_in    = day_ff;
      year_in   = year_ff;
      ok_in     = 1'b0;
      if (s1_op_ff == cdc_pkg::OP_SET) begin
         if (s1_month_ff >= 4'd1 && s1_month_ff <= 4'd12 && s1_day_ff != 5'd0 &&
             s1_day_ff <= set_len && s1_year_ff != '0 && s1_year_ff >= min_year_ff &&
             17'(s1_year_ff) <= 17'(YEAR_MAX)) begin
            month_in = s1_month_ff;
            day_in   = s1_day_ff;
            year_in  = YEAR_BITS'(s1_year_ff);
            ok_in    = 1'b1;
         end
      end else if (day_ff < cur_len) begin
         day_in = day_ff + 5'd1;
         ok_in  = 1'b1;
      end else if (month_ff < 4'd12) begin
         month_in = month_ff + 4'd1;
         day_in   = 5'd1;
         ok_in    = 1'b1;
      end else if (year_ff != YEAR_MAX) begin
         month_in = 4'd1;
         day_in   = 5'd1;
         year_in  = year_ff + YEAR_BITS'(1);
         ok_in    = 1'b1;
      end
   end

   always_comb begin
      adj_year = (s2_month_ff < 4'd3 && s2_year_ff != '0) ? s2_year_ff - YEAR_BITS'(1)
                                                          : s2_year_ff;
      div_prod = PROD_BITS'(adj_year) * PROD_BITS'(cdc_pkg::DIV100_MUL);
      wd_sum   = SUM_BITS'(s3_adj_ff) + SUM_BITS'(s3_adj_ff >> 2)
               - SUM_BITS'(s3_q100_ff) + SUM_BITS'(s3_q100_ff >> 2)
               + SUM_BITS'(s3_od_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff <= cdc_pkg::MIN_YEAR_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         month_ff    <= 4'd1;
         day_ff      <= 5'd1;
         year_ff     <= YEAR_BITS'(cdc_pkg::RESET_YEAR);
      end else begin
         if (csr_write_enable) begin
            min_year_ff <= csr_write_data;
         end
         if (s1_free) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               month_ff <= month_in;
               day_ff   <= day_in;
               year_ff  <= year_in;
            end
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_free) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_chan.valid) begin
         s1_op_ff    <= cdc_pkg::op_type'(req_chan.operation);
         s1_month_ff <= req_chan.new_month;
         s1_day_ff   <= req_chan.new_day;
         s1_year_ff  <= req_chan.new_year;
      end
      if (s2_free && s1_valid_ff) begin
         s2_month_ff <= month_in;
         s2_day_ff   <= day_in;
         s2_year_ff  <= year_in;
         s2_ok_ff    <= ok_in;
      end
      if (s3_free && s2_valid_ff) begin
         s3_month_ff <= s2_month_ff;
         s3_day_ff   <= s2_day_ff;
         s3_year_ff  <= s2_year_ff;
         s3_ok_ff    <= s2_ok_ff;
         s3_adj_ff   <= adj_year;
         s3_q100_ff  <= div_prod[cdc_pkg::DIV100_SHIFT +: Q_BITS];
         s3_od_ff    <= 6'(cdc_pkg::month_offset(s2_month_ff)) + 6'(s2_day_ff);
      end
      if (s4_free && s3_valid_ff) begin
         s4_month_ff   <= s3_month_ff;
         s4_day_ff     <= s3_day_ff;
         s4_year_ff    <= s3_year_ff;
         s4_ok_ff      <= s3_ok_ff;
         s4_weekday_ff <= cdc_pkg::mod7(wd_sum);
      end
   end

   assign rsp_chan.valid     = s4_valid_ff;
   assign rsp_chan.cur_month = s4_month_ff;
   assign rsp_chan.cur_day   = s4_day_ff;
   assign rsp_chan.cur_year  = s4_year_ff;
   assign rsp_chan.weekday   = s4_weekday_ff;
   assign rsp_chan.accepted  = s4_ok_ff;

   a_date_valid: assert property (@(posedge clock) disable iff (reset)
      month_ff >= 4'd1 && month_ff <= 4'd12 && day_ff != 5'd0 && year_ff != '0)
      else $error("stored date out of range");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff)
      else $error("request stalled with a free stage");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.weekday != 3'd7)
      else $error("weekday out of range");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s2_free) |=> $stable(month_ff) && $stable(day_ff) && $stable(year_ff))
      else $error("date changed without an item");

endmodule
